// ===== src/c3rc_pkg.sv =====
// ----------------------------------------------------------------------------
// c3rc_pkg
// Shared widths, constants and register map for the 3x3 RGB convolution.
// ----------------------------------------------------------------------------
package c3rc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int CH_W   = 8;             // one colour channel
  localparam int PIX_W  = 3 * CH_W;      // packed RGB pixel
  localparam int TAPS   = 9;             // 3x3 window
  localparam int PROD_W = 17;            // 9-bit signed pixel times 8-bit signed weight
  localparam int SUM_W  = 21;            // nine products, with headroom
  localparam int CH_MAX = 255;

  localparam int IMG_W_W = 13;           // image_width register
  localparam int KROW_W  = 24;           // one kernel row register
  localparam int MIN_WIDTH = 3;
  localparam int ROWS_FULL = 2;          // rows_seen saturation point

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = IMG_W_W'(640);
  localparam logic [KROW_W-1:0]  KROW_TOP_RST    = KROW_W'(0);
  localparam logic [KROW_W-1:0]  KROW_MID_RST    = KROW_W'(256);
  localparam logic [KROW_W-1:0]  KROW_BOT_RST    = KROW_W'(0);

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = CH_W'(255);

  // register index, paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_KROW_TOP    = 2'd1;
  localparam logic [1:0] REG_KROW_MID    = 2'd2;
  localparam logic [1:0] REG_KROW_BOT    = 2'd3;

  typedef logic [TAPS-1:0][CH_W-1:0] tap_bytes_t;

endpackage

// ===== src/c3rc_linebuf.sv =====
// ----------------------------------------------------------------------------
// c3rc_linebuf
// Two line stores in one memory word per column, with write-to-read bypass.
// ----------------------------------------------------------------------------
module c3rc_linebuf
  import c3rc_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_pix,
  output logic [PIX_W-1:0] rd_upper,
  output logic [PIX_W-1:0] rd_lower
);

  // word: [PIX_W-1:0] row above, [2*PIX_W-1:PIX_W] row two above
  logic [2*PIX_W-1:0] mem [DEPTH];
  logic [2*PIX_W-1:0] rd_mem;
  logic [2*PIX_W-1:0] fwd_data;
  logic               fwd_hit;
  logic [2*PIX_W-1:0] wr_word;

  // the lower row moves up, the new pixel becomes the lower row
  assign wr_word  = {rd_lower, wr_pix};
  assign rd_upper = fwd_hit ? fwd_data[2*PIX_W-1:PIX_W] : rd_mem[2*PIX_W-1:PIX_W];
  assign rd_lower = fwd_hit ? fwd_data[PIX_W-1:0]       : rd_mem[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  // same-column read in the write cycle (back-to-back frame starts) takes the bypass
  always_ff @(posedge clk) begin
    if (en) begin
      rd_mem   <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_word;
    end
  end

endmodule

// ===== src/c3rc_mac.sv =====
// ----------------------------------------------------------------------------
// c3rc_mac
// One colour channel: nine products, registered, then sum and clamp to 0..255.
// ----------------------------------------------------------------------------
module c3rc_mac
  import c3rc_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  tap_bytes_t      pix,
  input  tap_bytes_t      wgt,
  output logic [CH_W-1:0] result
);

  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [SUM_W-1:0]  sum;
  logic [CH_W-1:0]          clamped;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= PROD_W'($signed({1'b0, pix[i]})) * PROD_W'($signed(wgt[i]));
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + SUM_W'(prod[i]);
    end
  end

  always_comb begin
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > SUM_W'(CH_MAX)) begin
      clamped = CH_W'(CH_MAX);
    end else begin
      clamped = sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= clamped;
    end
  end

endmodule

// ===== src/conv3x3_rgb_clamp_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_rgb_clamp_top
// Streaming 3x3 convolution of RGB pixels, per channel, clamped to 0..255.
// ----------------------------------------------------------------------------
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        tdata {blue,green,red}, tuser frame_start
// m_*       out  m_tvalid / m_tready        tdata {alpha,blue,green,red}
// apb       in   psel, penable, pwrite      paddr[3:2] register, pwdata / prdata
//
// One pixel word per clock unless stalled. Each result passes, in order:
// line store read, window shift, product register, sum/clamp output register.
// All stages move together; a held m_tready stalls the whole pipe and drops
// s_tready. Synchronous reset clears control, window and registers; the line
// stores are not cleared and need no pass after reset.
// ----------------------------------------------------------------------------
module conv3x3_rgb_clamp_top
  import c3rc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [PIX_W-1:0]    s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                s_tuser,   // frame_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [4*CH_W-1:0]   m_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;

  // config
  logic [IMG_W_W-1:0] image_width;
  logic [KROW_W-1:0]  kernel_row_top;
  logic [KROW_W-1:0]  kernel_row_middle;
  logic [KROW_W-1:0]  kernel_row_bottom;
  logic               cfg_wr;

  // position
  logic [AW-1:0] column_index, column_index_next, col_cur;
  logic [1:0]    rows_seen, rows_seen_next, rows_cur;
  logic [CW-1:0] width_ext, eff_width, col_inc;
  logic          produce;

  // pipeline
  logic             advance, accept;
  logic             s1_valid, s1_prod;
  logic [AW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_pix;
  logic             win_valid, prod_valid;
  logic [TAPS-1:0][PIX_W-1:0] window;
  logic [PIX_W-1:0] top_pix, mid_pix;
  logic [2:0][CH_W-1:0] ch_result;
  tap_bytes_t       ch_pix [3];
  tap_bytes_t       wgt;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= IMAGE_WIDTH_RST;
      kernel_row_top    <= KROW_TOP_RST;
      kernel_row_middle <= KROW_MID_RST;
      kernel_row_bottom <= KROW_BOT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH: image_width       <= pwdata[IMG_W_W-1:0];
        REG_KROW_TOP:    kernel_row_top    <= pwdata[KROW_W-1:0];
        REG_KROW_MID:    kernel_row_middle <= pwdata[KROW_W-1:0];
        REG_KROW_BOT:    kernel_row_bottom <= pwdata[KROW_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH: prdata = 32'(image_width);
      REG_KROW_TOP:    prdata = 32'(kernel_row_top);
      REG_KROW_MID:    prdata = 32'(kernel_row_middle);
      REG_KROW_BOT:    prdata = 32'(kernel_row_bottom);
    endcase
  end

  // ---------------- column / row tracking ----------------
  assign col_cur  = s_tuser ? '0 : column_index;
  assign rows_cur = s_tuser ? '0 : rows_seen;

  always_comb begin
    width_ext = CW'(image_width);
    if (width_ext < CW'(MIN_WIDTH)) begin
      eff_width = CW'(MIN_WIDTH);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
  end

  // width shrunk mid-frame: column past the end still closes the row here
  always_comb begin
    col_inc           = CW'(col_cur) + CW'(1);
    column_index_next = col_inc[AW-1:0];
    rows_seen_next    = rows_cur;
    if (col_inc >= eff_width) begin
      column_index_next = '0;
      if (rows_cur < 2'(ROWS_FULL)) begin
        rows_seen_next = rows_cur + 2'd1;
      end
    end
  end

  assign produce = (rows_cur >= 2'(ROWS_FULL)) && (CW'(col_cur) >= CW'(2));

  // ---------------- line stores ----------------
  c3rc_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk      (clk),
    .en       (advance),
    .rd_addr  (col_cur),
    .wr_en    (s1_valid && advance),
    .wr_addr  (s1_addr),
    .wr_pix   (s1_pix),
    .rd_upper (top_pix),
    .rd_lower (mid_pix)
  );

  // ---------------- control and window ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      rows_seen    <= '0;
      s1_valid     <= 1'b0;
      win_valid    <= 1'b0;
      prod_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
      window       <= '0;
    end else if (advance) begin
      s1_valid   <= s_tvalid;
      win_valid  <= s1_valid && s1_prod;
      prod_valid <= win_valid;
      m_tvalid   <= prod_valid;
      if (accept) begin
        column_index <= column_index_next;
        rows_seen    <= rows_seen_next;
      end
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          window[r*3]     <= window[r*3 + 1];
          window[r*3 + 1] <= window[r*3 + 2];
        end
        window[2] <= top_pix;
        window[5] <= mid_pix;
        window[8] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix  <= s_tdata;
      s1_addr <= col_cur;
      s1_prod <= produce;
    end
  end

  // ---------------- per-channel arithmetic ----------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wgt[c]     = kernel_row_top[8*c +: 8];
      wgt[3 + c] = kernel_row_middle[8*c +: 8];
      wgt[6 + c] = kernel_row_bottom[8*c +: 8];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < TAPS; i++) begin
        ch_pix[ch][i] = window[i][CH_W*ch +: CH_W];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    c3rc_mac u_mac (
      .clk    (clk),
      .en     (advance),
      .pix    (ch_pix[ch]),
      .wgt    (wgt),
      .result (ch_result[ch])
    );
  end

  assign m_tdata = {ALPHA_OPAQUE, ch_result[2], ch_result[1], ch_result[0]};

endmodule
